// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the EBML header parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/ebml_pkg.sv -----
// Package with the widths, phase codes, status codes and helpers of the EBML header parser.
package ebml_pkg;

    localparam int BYTE_W = 8;
    localparam int ID_W   = 32;
    localparam int SIZE_W = 56;
    localparam int LEN_W  = 5;
    localparam int STAT_W = 2;
    localparam int LEFT_W = 3;
    localparam int LZ_W   = 4;

    // Parser phases.
    localparam logic [1:0] PH_ID_LEAD = 2'd0;
    localparam logic [1:0] PH_ID_MORE = 2'd1;
    localparam logic [1:0] PH_SZ_LEAD = 2'd2;
    localparam logic [1:0] PH_SZ_MORE = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_ID_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_SZ_ZERO = 2'd2;

    localparam logic [BYTE_W-1:0] MARK_BIT = 8'h80;
    localparam logic [BYTE_W-1:0] LOW_BITS = 8'h7F;
    localparam logic [LZ_W-1:0]   LZ_NONE  = 4'd8;

    // Count of leading zero bits in a byte; eight for a zero byte.
    function automatic logic [LZ_W-1:0] lead_zeros(input logic [BYTE_W-1:0] b);
        logic [LZ_W-1:0] n;
        n = LZ_NONE;
        for (int i = 0; i < BYTE_W; i++) begin
            if (b[i]) begin
                n = LZ_W'(BYTE_W - 1 - i);
            end
        end
        return n;
    endfunction

endpackage

// ----- hw/rtl/ebml_element_header_parser.sv -----
// Top level of the EBML element header parser: byte stream in, decoded header out.
//
//  Channel | Ports                                   | Direction | Moves
//  --------+-----------------------------------------+-----------+---------------------------
//  input   | s_valid, s_ready, s_byte_in             | in        | one header byte a request
//  result  | m_valid, m_ready, m_element_id,         | out       | one decoded header or an
//          | m_element_size, m_header_length,        |           | error a request
//          | m_status                                |           |
//
// One byte is taken every cycle while s_ready is high; a byte is decoded from the input register
// once the output register can take a result, and any result is loaded at the edge that consumes it.
// The input register and the output register each hold one request, so a result that
// waits for m_ready does not stop the next byte from being taken unless both are full.
// Reset (aresetn low at a clock edge) empties both registers and returns to the ID lead.
// A result is produced on the last byte of the size integer or on a zero lead byte.
`include "assert_macros.svh"

module ebml_element_header_parser (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ebml_pkg::BYTE_W-1:0]        s_byte_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ebml_pkg::ID_W-1:0]          m_element_id,
    output logic [ebml_pkg::SIZE_W-1:0]        m_element_size,
    output logic [ebml_pkg::LEN_W-1:0]         m_header_length,
    output logic [ebml_pkg::STAT_W-1:0]        m_status
);

    // Input register.
    logic                           in_valid_reg;
    logic [ebml_pkg::BYTE_W-1:0]    in_byte_reg;

    // Parser state.
    logic [1:0]                     phase_reg, phase_next;
    logic [ebml_pkg::LEFT_W-1:0]    left_reg, left_next;
    logic [ebml_pkg::ID_W-1:0]      id_reg, id_next;
    logic [ebml_pkg::SIZE_W-1:0]    size_reg, size_next;
    logic [ebml_pkg::LEN_W-1:0]     count_reg, count_next;

    // Output register.
    logic                           out_valid_reg;
    logic [ebml_pkg::ID_W-1:0]      out_id_reg;
    logic [ebml_pkg::SIZE_W-1:0]    out_size_reg;
    logic [ebml_pkg::LEN_W-1:0]     out_len_reg;
    logic [ebml_pkg::STAT_W-1:0]    out_stat_reg;

    // Decode results of the byte in the input register.
    logic                           res_valid;
    logic [ebml_pkg::ID_W-1:0]      res_id;
    logic [ebml_pkg::SIZE_W-1:0]    res_size;
    logic [ebml_pkg::LEN_W-1:0]     res_len;
    logic [ebml_pkg::STAT_W-1:0]    res_stat;

    logic                           out_free;
    logic                           proc_fire;
    logic [ebml_pkg::LZ_W-1:0]      lz;
    logic [ebml_pkg::LEN_W-1:0]     count_inc;
    logic [ebml_pkg::LEFT_W-1:0]    left_dec;
    logic [ebml_pkg::BYTE_W-1:0]    low_mask;

    // Handshake: the byte is decoded when the output register can take a result.
    assign out_free  = !out_valid_reg || m_ready;
    assign proc_fire = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;

    assign lz        = ebml_pkg::lead_zeros(in_byte_reg);
    assign count_inc = count_reg + ebml_pkg::LEN_W'(1);
    assign left_dec  = left_reg - ebml_pkg::LEFT_W'(1);
    assign low_mask  = ebml_pkg::LOW_BITS >> lz;

    // Per-byte decode of the variable-length integers.
    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        id_next    = id_reg;
        size_next  = size_reg;
        count_next = count_reg;
        res_valid  = 1'b0;
        res_id     = id_reg;
        res_size   = size_reg;
        res_len    = count_inc;
        res_stat   = ebml_pkg::ST_OK;
        unique case (phase_reg)
            ebml_pkg::PH_ID_LEAD: begin
                count_next = ebml_pkg::LEN_W'(1);
                if (lz == ebml_pkg::LZ_NONE) begin
                    res_valid  = 1'b1;
                    res_id     = '0;
                    res_size   = '0;
                    res_len    = ebml_pkg::LEN_W'(1);
                    res_stat   = ebml_pkg::ST_ID_ZERO;
                    count_next = '0;
                    left_next  = '0;
                end else begin
                    id_next    = ebml_pkg::ID_W'(in_byte_reg);
                    left_next  = lz[ebml_pkg::LEFT_W-1:0];
                    phase_next = (lz == '0) ? ebml_pkg::PH_SZ_LEAD : ebml_pkg::PH_ID_MORE;
                end
            end
            ebml_pkg::PH_ID_MORE: begin
                count_next = count_inc;
                id_next    = {id_reg[ebml_pkg::ID_W-ebml_pkg::BYTE_W-1:0], in_byte_reg};
                left_next  = left_dec;
                if (left_dec == '0) begin
                    phase_next = ebml_pkg::PH_SZ_LEAD;
                end
            end
            ebml_pkg::PH_SZ_LEAD: begin
                count_next = count_inc;
                if (lz == ebml_pkg::LZ_NONE) begin
                    res_valid  = 1'b1;
                    res_id     = '0;
                    res_size   = '0;
                    res_stat   = ebml_pkg::ST_SZ_ZERO;
                    phase_next = ebml_pkg::PH_ID_LEAD;
                    count_next = '0;
                    left_next  = '0;
                end else begin
                    size_next = ebml_pkg::SIZE_W'(in_byte_reg & low_mask);
                    left_next = lz[ebml_pkg::LEFT_W-1:0];
                    if (lz == '0) begin
                        res_valid  = 1'b1;
                        res_size   = ebml_pkg::SIZE_W'(in_byte_reg & low_mask);
                        phase_next = ebml_pkg::PH_ID_LEAD;
                        count_next = '0;
                    end else begin
                        phase_next = ebml_pkg::PH_SZ_MORE;
                    end
                end
            end
            ebml_pkg::PH_SZ_MORE: begin
                count_next = count_inc;
                size_next  = {size_reg[ebml_pkg::SIZE_W-ebml_pkg::BYTE_W-1:0], in_byte_reg};
                left_next  = left_dec;
                if (left_dec == '0) begin
                    res_valid  = 1'b1;
                    res_size   = {size_reg[ebml_pkg::SIZE_W-ebml_pkg::BYTE_W-1:0],
                                  in_byte_reg};
                    phase_next = ebml_pkg::PH_ID_LEAD;
                    count_next = '0;
                end
            end
            default: begin
                phase_next = ebml_pkg::PH_ID_LEAD;
            end
        endcase
    end

    // Input register: takes a byte whenever it is empty or being consumed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_in;
        end
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ebml_pkg::PH_ID_LEAD;
            left_reg  <= '0;
            count_reg <= '0;
            id_reg    <= '0;
            size_reg  <= '0;
        end else if (proc_fire) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            count_reg <= count_next;
            id_reg    <= id_next;
            size_reg  <= size_next;
        end
    end

    // Output register: loads a result, empties when the request is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= proc_fire && res_valid;
        end
        if (proc_fire && res_valid) begin
            out_id_reg   <= res_id;
            out_size_reg <= res_size;
            out_len_reg  <= res_len;
            out_stat_reg <= res_stat;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_element_id    = out_id_reg;
    assign m_element_size  = out_size_reg;
    assign m_header_length = out_len_reg;
    assign m_status        = out_stat_reg;

    // A decoded result always reaches the output register on the next edge.
    `ASSERT_NEXT(a_result_loads, aclk, aresetn, proc_fire && res_valid, out_valid_reg)
    // ID continuation bytes never end a header.
    `ASSERT_SAME(a_no_result_mid_id, aclk, aresetn, phase_reg == ebml_pkg::PH_ID_MORE,
                 !res_valid)
    // At most eight ID bytes and seven size bytes are counted before the last byte.
    `ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= ebml_pkg::LEN_W'(15))
    // A zero ID lead byte gives a one-byte error header with cleared fields.
    `ASSERT_SAME(a_id_error_form, aclk, aresetn,
                 out_valid_reg && out_stat_reg == ebml_pkg::ST_ID_ZERO,
                 out_len_reg == ebml_pkg::LEN_W'(1) && out_id_reg == '0 && out_size_reg == '0)
    // A good header holds at least an ID byte and a size byte.
    `ASSERT_SAME(a_ok_length, aclk, aresetn,
                 out_valid_reg && out_stat_reg == ebml_pkg::ST_OK,
                 out_len_reg >= ebml_pkg::LEN_W'(2))

endmodule
